>>> hw/rtl/ipa_pkg.sv
// shared types and constants of the interval partition assigner
`timescale 1ns / 1ps

package ipa_pkg;

    localparam int MAX_PREFIX_BITS = 10;
    localparam int TIME_WIDTH      = 32;
    localparam int ID_WIDTH        = 32;
    localparam int COUNT_WIDTH     = 32;

    localparam int PART_W     = MAX_PREFIX_BITS;
    localparam int ROW_W      = MAX_PREFIX_BITS + 1;
    localparam int CNT_ADDR_W = ROW_W + 2;
    localparam int POS_W      = MAX_PREFIX_BITS + 2;
    localparam int LEVEL_W    = 4;
    localparam int SHIFT_W    = 6;
    localparam int PB_W       = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_BITS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVELS      = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_PLACE  = 2'd0;
    localparam logic [1:0] KIND_REJECT = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    // placement classes
    localparam logic [1:0] CLS_ORIG_IN     = 2'd0;
    localparam logic [1:0] CLS_ORIG_AFTER  = 2'd1;
    localparam logic [1:0] CLS_REPL_IN     = 2'd2;
    localparam logic [1:0] CLS_REPL_AFTER  = 2'd3;

    typedef struct packed {
        logic                  action;
        logic [ID_WIDTH-1:0]   record_id;
        logic [TIME_WIDTH-1:0] interval_start;
        logic [TIME_WIDTH-1:0] interval_end;
    } t_in;

    typedef struct packed {
        logic [1:0]             out_kind;
        logic [ID_WIDTH-1:0]    out_record_id;
        logic [LEVEL_W-1:0]     out_level;
        logic [PART_W-1:0]      out_partition;
        logic [1:0]             out_class;
        logic [COUNT_WIDTH-1:0] out_slot;
        logic                   out_saturated;
        logic                   last;
    } t_out;

    typedef struct packed {
        logic                  rd_en;
        logic                  inc;
        logic                  clr;
        logic [CNT_ADDR_W-1:0] addr;
    } t_cnt_req;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] slot;
        logic                   saturated;
    } t_cnt_rsp;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_SETUP,
        S_LEVEL,
        S_UPD,
        S_DONE
    } t_state;

endpackage

>>> hw/rtl/interval_partition_assigner.sv
// top level: interval placement walk over a hierarchical partition index
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+------------------------------
//   in      | input     | i_in_valid / o_in_stall  | i_in  (action, id, start, end)
//   out     | output    | o_out_valid / i_out_stall| o_out (kind .. slot, last)
//   cfg     | input     | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// one item at a time: the item is accepted, then set up; each placement reads
// its counter, then increments and writes it back on the single counter memory;
// each level that ends without a further placement steps on to the next level,
// and a final step finishes. a full walk makes at most 22 placements over 11 levels.
// after reset and for each clear, all 8192 counters are zeroed one per cycle
// while no item is accepted; cfg writes are always taken.
// a stalled output holds the walk at the next placement; one result is kept
// back until the walk knows whether it is the last one.
`timescale 1ns / 1ps

module interval_partition_assigner (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  ipa_pkg::t_in                     i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output ipa_pkg::t_out                    o_out,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ipa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ipa_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import ipa_pkg::*;

    localparam logic [ROW_W:0] ROWS = {1'b1, {ROW_W{1'b0}}};

    t_state r_state, n_state;

    logic [PB_W-1:0]    r_prefix_bits;
    logic [SHIFT_W-1:0] r_time_bits;
    logic [LEVEL_W-1:0] r_levels;

    logic [ID_WIDTH-1:0]   r_id;
    logic [TIME_WIDTH-1:0] r_st, r_en;

    logic signed [POS_W-1:0] r_a, n_a, r_b, n_b;
    logic [LEVEL_W-1:0]      r_lvl, n_lvl, r_nlev, n_nlev;
    logic                    r_first, n_first, r_lastf, n_lastf;
    logic                    r_is_b, n_is_b;
    logic [1:0]              r_cls, n_cls;
    logic [PART_W-1:0]       r_part, n_part;
    logic [CNT_ADDR_W-1:0]   r_sweep, n_sweep;
    logic                    r_pend_valid, n_pend_valid;
    t_out                    r_pend, n_pend;
    logic                    r_out_valid;
    t_out                    r_out, n_out;
    logic                    load_out;

    t_cnt_req req;
    t_cnt_rsp rsp;

    logic in_accept, out_free;

    // setup arithmetic
    logic [PB_W-1:0]       w_pb;
    logic [SHIFT_W-1:0]    w_tb, w_shift;
    logic [PART_W-1:0]     w_top, w_a0, w_b0;
    logic [TIME_WIDTH-1:0] w_a_sh, w_b_sh;
    logic [LEVEL_W:0]      w_pb1;
    logic [LEVEL_W-1:0]    w_nlev;

    // level step
    logic [1:0]       w_cls_a, w_cls_b;
    logic             w_eq, w_b_less;
    logic [ROW_W:0]   w_base, w_row;
    logic [PART_W-1:0] w_part;
    logic [1:0]       w_cls;
    logic [LEVEL_W-1:0] w_lvl_next;

    assign in_accept   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    ipa_counter_bank u_bank (
        .i_clk (i_clk),
        .i_req (req),
        .o_rsp (rsp)
    );

    always_comb begin
        w_pb    = (r_prefix_bits > PB_W'(MAX_PREFIX_BITS)) ? PB_W'(MAX_PREFIX_BITS)
                                                           : r_prefix_bits;
        w_tb    = (r_time_bits > SHIFT_W'(TIME_WIDTH)) ? SHIFT_W'(TIME_WIDTH) : r_time_bits;
        w_shift = (w_tb > SHIFT_W'(w_pb)) ? w_tb - SHIFT_W'(w_pb) : '0;
        w_top   = ~({PART_W{1'b1}} << w_pb);
        w_a_sh  = r_st >> w_shift;
        w_b_sh  = r_en >> w_shift;
        w_a0    = (w_a_sh > TIME_WIDTH'(w_top)) ? w_top : w_a_sh[PART_W-1:0];
        w_b0    = (w_b_sh > TIME_WIDTH'(w_top)) ? w_top : w_b_sh[PART_W-1:0];
        w_pb1   = (LEVEL_W+1)'(w_pb) + (LEVEL_W+1)'(1);
        w_nlev  = ((LEVEL_W+1)'(r_levels) > w_pb1) ? w_pb1[LEVEL_W-1:0] : r_levels;
    end

    always_comb begin
        w_eq     = (r_a == r_b);
        w_b_less = ((r_b - POS_W'(1)) < r_a);
        if (w_eq && !r_lastf) begin
            w_cls_a = r_first ? CLS_REPL_IN : CLS_ORIG_IN;
        end else begin
            w_cls_a = r_first ? CLS_REPL_AFTER : CLS_ORIG_AFTER;
        end
        // even end: stays original only while nothing was placed and it drops below a
        if (!r_first && w_b_less) begin
            w_cls_b = r_lastf ? CLS_ORIG_AFTER : CLS_ORIG_IN;
        end else begin
            w_cls_b = r_lastf ? CLS_REPL_AFTER : CLS_REPL_IN;
        end
        w_part     = r_a[0] ? r_a[PART_W-1:0] : r_b[PART_W-1:0];
        w_cls      = r_a[0] ? w_cls_a : w_cls_b;
        w_base     = ROWS - (ROWS >> r_lvl);
        w_row      = w_base + (ROW_W+1)'(w_part);
        w_lvl_next = r_lvl + LEVEL_W'(1);
    end

    always_comb begin
        n_state      = r_state;
        n_a          = r_a;
        n_b          = r_b;
        n_lvl        = r_lvl;
        n_nlev       = r_nlev;
        n_first      = r_first;
        n_lastf      = r_lastf;
        n_is_b       = r_is_b;
        n_cls        = r_cls;
        n_part       = r_part;
        n_sweep      = r_sweep;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out        = r_pend;
        load_out     = 1'b0;
        req          = '0;

        unique case (r_state)
            S_SWEEP: begin
                req.clr  = 1'b1;
                req.addr = r_sweep;
                n_sweep  = r_sweep + CNT_ADDR_W'(1);
                if (&r_sweep) begin
                    n_state = S_DONE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    if (i_in.action) begin
                        n_pend_valid      = 1'b1;
                        n_pend            = '0;
                        n_pend.out_kind   = KIND_CLEAR;
                        n_sweep           = '0;
                        n_state           = S_SWEEP;
                    end else if (i_in.interval_start > i_in.interval_end) begin
                        n_pend_valid         = 1'b1;
                        n_pend               = '0;
                        n_pend.out_kind      = KIND_REJECT;
                        n_pend.out_record_id = i_in.record_id;
                        n_state              = S_DONE;
                    end else begin
                        n_state = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                n_a     = POS_W'(w_a0);
                n_b     = POS_W'(w_b0);
                n_lvl   = '0;
                n_nlev  = w_nlev;
                n_first = 1'b0;
                n_lastf = 1'b0;
                n_state = (w_nlev == '0) ? S_DONE : S_LEVEL;
            end
            S_LEVEL: begin
                if (r_a[0] || !r_b[0]) begin
                    req.rd_en = 1'b1;
                    req.addr  = {w_row[ROW_W-1:0], w_cls};
                    n_is_b    = !r_a[0];
                    n_cls     = w_cls;
                    n_part    = w_part;
                    n_state   = S_UPD;
                end else if ((w_lvl_next == r_nlev) || (r_a > r_b)) begin
                    n_state = S_DONE;
                end else begin
                    n_a   = r_a >>> 1;
                    n_b   = r_b >>> 1;
                    n_lvl = w_lvl_next;
                end
            end
            S_UPD: begin
                if (!r_pend_valid || out_free) begin
                    req.inc  = 1'b1;
                    load_out = r_pend_valid;
                    n_out.last            = 1'b0;
                    n_pend_valid          = 1'b1;
                    n_pend.out_kind       = KIND_PLACE;
                    n_pend.out_record_id  = r_id;
                    n_pend.out_level      = r_lvl;
                    n_pend.out_partition  = r_part;
                    n_pend.out_class      = r_cls;
                    n_pend.out_slot       = rsp.slot;
                    n_pend.out_saturated  = rsp.saturated;
                    n_pend.last           = 1'b0;
                    if (r_is_b) begin
                        n_b = r_b - POS_W'(1);
                    end else begin
                        n_a     = r_a + POS_W'(1);
                        n_first = 1'b1;
                    end
                    if (r_cls == CLS_REPL_IN) begin
                        n_lastf = 1'b1;
                    end
                    n_state = S_LEVEL;
                end
            end
            S_DONE: begin
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    load_out     = 1'b1;
                    n_out.last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_SWEEP;
            r_sweep       <= '0;
            r_pend_valid  <= 1'b0;
            r_out_valid   <= 1'b0;
            r_prefix_bits <= PB_W'(10);
            r_time_bits   <= SHIFT_W'(32);
            r_levels      <= LEVEL_W'(11);
        end else begin
            r_state      <= n_state;
            r_sweep      <= n_sweep;
            r_pend_valid <= n_pend_valid;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_PREFIX_BITS: r_prefix_bits <= i_cfg_data[PB_W-1:0];
                    CFG_TIME_BITS:   r_time_bits   <= i_cfg_data[SHIFT_W-1:0];
                    CFG_LEVELS:      r_levels      <= i_cfg_data[LEVEL_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a     <= n_a;
        r_b     <= n_b;
        r_lvl   <= n_lvl;
        r_nlev  <= n_nlev;
        r_first <= n_first;
        r_lastf <= n_lastf;
        r_is_b  <= n_is_b;
        r_cls   <= n_cls;
        r_part  <= n_part;
        r_pend  <= n_pend;
        if (load_out) begin
            r_out <= n_out;
        end
        if (in_accept) begin
            r_id <= i_in.record_id;
            r_st <= i_in.interval_start;
            r_en <= i_in.interval_end;
        end
    end

endmodule

>>> hw/rtl/ipa_counter_bank.sv
// placement counter memory with saturating increment of the last entry read
`timescale 1ns / 1ps

module ipa_counter_bank (
    input  logic              i_clk,
    input  ipa_pkg::t_cnt_req i_req,
    output ipa_pkg::t_cnt_rsp o_rsp
);
    import ipa_pkg::*;

    localparam int DEPTH = 1 << CNT_ADDR_W;

    logic [COUNT_WIDTH-1:0] r_mem [DEPTH];
    logic [COUNT_WIDTH-1:0] r_rdata;
    logic [CNT_ADDR_W-1:0]  r_raddr;
    logic                   w_sat;

    assign w_sat = &r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rdata <= r_mem[i_req.addr];
            r_raddr <= i_req.addr;
        end
    end

    // the increment goes back to the entry read last
    always_ff @(posedge i_clk) begin
        if (i_req.clr) begin
            r_mem[i_req.addr] <= '0;
        end else if (i_req.inc && !w_sat) begin
            r_mem[r_raddr] <= r_rdata + COUNT_WIDTH'(1);
        end
    end

    assign o_rsp.slot      = r_rdata;
    assign o_rsp.saturated = w_sat;

endmodule

>>> hw/rtl/ipa_checker.sv
// port-level checks of the interval partition assigner and their binding
`timescale 1ns / 1ps

module ipa_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input ipa_pkg::t_out o_out
);
    import ipa_pkg::*;

    // a reject or clear result is always marked last
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.out_kind != KIND_PLACE) |-> o_out.last)
        else $error("reject or clear result without last");

    a_sat_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.out_saturated |-> &o_out.out_slot)
        else $error("saturated result with slot below maximum");

    // one item in flight: a transfer is followed by stall
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again right after a transfer");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

endmodule

bind interval_partition_assigner ipa_checker u_ipa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

>>> bench/interval_partition_assigner_test.sv
// self-checking testbench of the interval partition assigner
`timescale 1ns / 1ps

module interval_partition_assigner_test;
    import ipa_pkg::*;

    localparam int CNT_DEPTH    = 4 << ROW_W;
    localparam int DRAIN_CYCLES = 120;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 57;
    localparam int NUM_PHASES   = 8;

    localparam logic ACT_PLACE = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in                   in_item   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out                  out_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // mirrored register file
    logic [3:0] cfg_prefix = 4'd10;
    logic [5:0] cfg_time   = 6'd32;
    logic [3:0] cfg_levels = 4'd11;

    logic [COUNT_WIDTH-1:0] slot_count [CNT_DEPTH];
    t_in  record_q    [$];
    t_out due_results [$];
    int   mismatches = 0;
    bit   src_gaps   = 1'b1;
    bit   sink_gaps  = 1'b1;
    int   hold_asked = 0;
    int   hold_done  = 0;
    int   hold_left  = 0;

    interval_partition_assigner i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    initial begin
        foreach (slot_count[i]) slot_count[i] = '0;
    end

    function automatic t_out take_slot(logic [ID_WIDTH-1:0] id, int lvl, int part,
                                       logic [1:0] cls);
        t_out r;
        int   base;
        int   idx;
        base = (1 << ROW_W) - (1 << (ROW_W - lvl));
        idx  = ((base + part) * 4 + cls) % CNT_DEPTH;
        r = '0;
        r.out_kind      = KIND_PLACE;
        r.out_record_id = id;
        r.out_level     = LEVEL_W'(lvl);
        r.out_partition = PART_W'(part);
        r.out_class     = cls;
        if (slot_count[idx] == {COUNT_WIDTH{1'b1}}) begin
            r.out_slot      = {COUNT_WIDTH{1'b1}};
            r.out_saturated = 1'b1;
        end else begin
            r.out_slot      = slot_count[idx];
            slot_count[idx] = slot_count[idx] + COUNT_WIDTH'(1);
        end
        return r;
    endfunction

    // walk the levels for one accepted record and queue the placements it makes
    function automatic void assign_slots(t_in rec);
        t_out        r;
        logic [63:0] st;
        logic [63:0] en;
        int          pb, tb, sh, nlev, top, a, b, pv, lvl, n;
        bit          first, lastf;
        logic [1:0]  cls;
        r = '0;
        if (rec.action == ACT_CLEAR) begin
            foreach (slot_count[i]) slot_count[i] = '0;
            r.out_kind = KIND_CLEAR;
            r.last     = 1'b1;
            due_results.push_back(r);
            return;
        end
        if (rec.interval_start > rec.interval_end) begin
            r.out_kind      = KIND_REJECT;
            r.out_record_id = rec.record_id;
            r.last          = 1'b1;
            due_results.push_back(r);
            return;
        end
        pb   = (cfg_prefix > MAX_PREFIX_BITS) ? MAX_PREFIX_BITS : cfg_prefix;
        tb   = (cfg_time > TIME_WIDTH) ? TIME_WIDTH : cfg_time;
        sh   = (tb > pb) ? tb - pb : 0;
        nlev = (cfg_levels > pb + 1) ? pb + 1 : cfg_levels;
        top  = (1 << pb) - 1;
        st   = {32'd0, rec.interval_start} >> sh;
        en   = {32'd0, rec.interval_end} >> sh;
        a    = (st > top) ? top : int'(st);
        b    = (en > top) ? top : int'(en);
        first = 1'b0;
        lastf = 1'b0;
        n     = 0;
        for (lvl = 0; lvl < nlev && a <= b; lvl++) begin
            if (a[0]) begin
                if (first) begin
                    if (a == b && !lastf) begin
                        cls   = CLS_REPL_IN;
                        lastf = 1'b1;
                    end else begin
                        cls = CLS_REPL_AFTER;
                    end
                end else begin
                    cls   = (a == b && !lastf) ? CLS_ORIG_IN : CLS_ORIG_AFTER;
                    first = 1'b1;
                end
                due_results.push_back(take_slot(rec.record_id, lvl, a, cls));
                n++;
                a++;
            end
            if (!b[0]) begin
                pv = b;
                // b at zero drops below a, which ends the walk
                b--;
                if (!first && b < a) begin
                    cls = lastf ? CLS_ORIG_AFTER : CLS_ORIG_IN;
                end else if (!lastf) begin
                    cls   = CLS_REPL_IN;
                    lastf = 1'b1;
                end else begin
                    cls = CLS_REPL_AFTER;
                end
                due_results.push_back(take_slot(rec.record_id, lvl, pv, cls));
                n++;
            end
            if (a > b) break;
            a = a >>> 1;
            b = b >>> 1;
        end
        if (n > 0) begin
            r = due_results.pop_back();
            r.last = 1'b1;
            due_results.push_back(r);
        end
    endfunction

    function automatic t_in rand_record();
        t_in         r;
        logic [31:0] x, y, span, low;
        int          pick;
        r.action    = ($urandom_range(0, 49) == 0) ? ACT_CLEAR : ACT_PLACE;
        r.record_id = $urandom;
        x    = $urandom;
        y    = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            if (x > y) {x, y} = {y, x};
        end else if (pick < 65) begin
            span = $urandom >> $urandom_range(0, 31);
            y    = (x > ~span) ? 32'hFFFF_FFFF : x + span;
        end else if (pick < 80) begin
            // partition aligned edges
            low = 32'hFFFF_FFFF >> $urandom_range(1, 31);
            if (x > y) {x, y} = {y, x};
            x = x & ~low;
            y = y | low;
        end else if (pick < 90) begin
            y = x;
        end else begin
            if (x < y) {x, y} = {y, x};
            if (x == y) begin
                if (x == 0) x = 32'd1;
                else y = x - 1;
            end
        end
        r.interval_start = x;
        r.interval_end   = y;
        return r;
    endfunction

    // input side: one transfer per accepted record
    always @(posedge clk) begin : feed_driver
        logic nxt_valid;
        t_in  nxt_item;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            nxt_valid = in_valid;
            nxt_item  = in_item;
            if (in_valid && !in_stall) begin
                assign_slots(in_item);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && record_q.size() != 0 &&
                !(src_gaps && $urandom_range(0, 99) < 25)) begin
                nxt_valid = 1'b1;
                nxt_item  = record_q.pop_front();
            end
            in_valid <= nxt_valid;
            in_item  <= nxt_item;
        end
    end

    always @(posedge clk) begin : hold_counter
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_done != hold_asked) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= hold_asked;
        end
    end

    always @(posedge clk) begin : sink_driver
        out_stall <= (hold_left != 0) || (sink_gaps && $urandom_range(0, 99) < 25);
    end

    always @(posedge clk) begin : reg_mirror
        if (!rst_n) begin
            cfg_prefix <= 4'd10;
            cfg_time   <= 6'd32;
            cfg_levels <= 4'd11;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_PREFIX_BITS: cfg_prefix <= cfg_data[3:0];
                CFG_TIME_BITS:   cfg_time   <= cfg_data;
                CFG_LEVELS:      cfg_levels <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t ns: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk) begin : result_monitor
        t_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (due_results.size() == 0) begin
                mismatches++;
                $display("%0t ns: unexpected result kind %0d id 0x%0h expected none",
                         $time, out_item.out_kind, out_item.out_record_id);
            end else begin
                want = due_results.pop_front();
                check_field("out_kind", 32'(want.out_kind), 32'(out_item.out_kind));
                check_field("out_record_id", want.out_record_id, out_item.out_record_id);
                check_field("out_level", 32'(want.out_level), 32'(out_item.out_level));
                check_field("out_partition", 32'(want.out_partition),
                            32'(out_item.out_partition));
                check_field("out_class", 32'(want.out_class), 32'(out_item.out_class));
                check_field("out_slot", want.out_slot, out_item.out_slot);
                check_field("out_saturated", 32'(want.out_saturated),
                            32'(out_item.out_saturated));
                check_field("last", 32'(want.last), 32'(out_item.last));
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(input int pb, input int tb, input int lv);
        write_reg(CFG_PREFIX_BITS, CFG_DATA_W'(pb));
        write_reg(CFG_TIME_BITS, CFG_DATA_W'(tb));
        write_reg(CFG_LEVELS, CFG_DATA_W'(lv));
        @(negedge clk);
    endtask

    task automatic queue_record(input logic act, input logic [31:0] id,
                                input logic [31:0] st, input logic [31:0] en);
        t_in r;
        r.action         = act;
        r.record_id      = id;
        r.interval_start = st;
        r.interval_end   = en;
        record_q.push_back(r);
    endtask

    // records that place nothing leave no trace, so allow the walk time to finish
    task automatic settle();
        do @(negedge clk); while (record_q.size() != 0 || in_valid || due_results.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial begin : stimulus
        int pb, tb, lv;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        queue_record(ACT_PLACE, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_record(ACT_PLACE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_record(ACT_PLACE, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000);
        queue_record(ACT_PLACE, 32'h0000_0002, 32'h0040_0000, 32'hFFBF_FFFF);
        queue_record(ACT_PLACE, 32'h0000_0003, 32'h0040_0000, 32'hFFBF_FFFF);
        queue_record(ACT_PLACE, 32'hA5A5_A5A5, 32'h0000_0005, 32'h0000_0004);
        queue_record(ACT_PLACE, 32'h0000_0007, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_record(ACT_CLEAR, 32'hDEAD_BEEF, 32'h0000_0001, 32'h0000_0002);
        queue_record(ACT_PLACE, 32'h0000_0008, 32'h0040_0000, 32'hFFBF_FFFF);
        queue_record(ACT_PLACE, 32'h0000_0009, 32'h1234_5678, 32'h1234_5678);
        settle();

        // out of range register values are clamped by the block
        set_regs(15, 63, 15);
        write_reg(CFG_UNUSED, 6'h3F);
        @(negedge clk);
        queue_record(ACT_PLACE, 32'h0000_000A, 32'h00C0_0000, 32'h7FFF_FFFF);
        queue_record(ACT_PLACE, 32'h0000_000B, 32'h0000_0000, 32'h003F_FFFF);
        settle();

        // time width below prefix width, stamps saturate at the top partition
        set_regs(8, 3, 9);
        queue_record(ACT_PLACE, 32'h0000_000C, 32'h0000_0100, 32'h0000_02FF);
        queue_record(ACT_PLACE, 32'h0000_000D, 32'h0000_0003, 32'h0000_00C8);
        settle();

        set_regs(8, 3, 0);
        queue_record(ACT_PLACE, 32'h0000_000E, 32'h0000_0000, 32'hFFFF_FFFF);
        settle();

        set_regs(4, 4, 1);
        queue_record(ACT_PLACE, 32'h0000_000F, 32'h0000_0000, 32'h0000_0001);
        queue_record(ACT_PLACE, 32'h0000_0010, 32'h0000_0002, 32'h0000_0005);
        settle();

        set_regs(0, 0, 11);
        queue_record(ACT_PLACE, 32'h0000_0011, 32'h0000_0000, 32'h0000_0000);
        queue_record(ACT_PLACE, 32'h0000_0012, 32'h8000_0000, 32'hFFFF_FFFF);
        settle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0, 1:    begin pb = 10; tb = 32; lv = 11; end
                2:       begin pb = 4;  tb = 12; lv = 5;  end
                3:       begin pb = 1;  tb = 1;  lv = 2;  end
                4:       begin pb = 10; tb = 10; lv = 11; end
                5:       begin pb = 6;  tb = 40; lv = 7;  end
                6:       begin pb = 3;  tb = 32; lv = 2;  end
                default: begin pb = 15; tb = 63; lv = 15; end
            endcase
            set_regs(pb, tb, lv);
            // one phase runs flat out with a long output hold at its start
            src_gaps  = (p != 1);
            sink_gaps = (p != 1);
            if (p == 1) hold_asked++;
            for (int k = 0; k < PHASE_ITEMS; k++) record_q.push_back(rand_record());
            settle();
        end

        if (mismatches == 0 && due_results.size() == 0)
            $display("interval_partition_assigner_test: PASS");
        else
            $display("interval_partition_assigner_test: FAIL");
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("interval_partition_assigner_test: FAIL");
        $finish;
    end

endmodule
